@@ src/bhsm_pkg.sv @@
// Shared types and constants for the branch history signature matcher.
// No dependencies; used by every module in src.
package bhsm_pkg;

    localparam int DEF_HISTORY_LEN    = 20;
    localparam int DEF_MAX_SIGNATURES = 1024;
    localparam int SIG_W              = 64;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_BRANCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } bhsm_state_t;

    typedef struct packed {
        logic load_wr;
        logic hist_shift;
        logic srch_clear;
        logic srch_step;
        logic res_set;
        logic res_full;
        logic res_hit;
    } bhsm_cmd_t;

    typedef struct packed {
        logic full_after_shift;
        logic table_empty;
        logic srch_hit;
        logic srch_miss;
    } bhsm_status_t;

endpackage

@@ src/bhsm_ctrl.sv @@
// Controller state machine: sequences load, shift, table search and result.
// Depends on bhsm_pkg.
module bhsm_ctrl
    import bhsm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         mode,
    input  logic         from_main_image,
    output logic         out_valid,
    input  logic         out_stall,
    output bhsm_cmd_t    cmd,
    input  bhsm_status_t status
);

    bhsm_state_t state_reg;
    bhsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else if (from_main_image)
                    begin
                        cmd.hist_shift = 1'b1;
                        if (!status.full_after_shift || status.table_empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_full = status.full_after_shift;
                            cmd.res_hit  = 1'b0;
                            state_next   = ST_RESULT;
                        end
                        else
                        begin
                            cmd.srch_clear = 1'b1;
                            state_next     = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.srch_step = 1'b1;
                if (status.srch_hit || status.srch_miss)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_full = 1'b1;
                    cmd.res_hit  = status.srch_hit;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/bhsm_dp.sv @@
// Datapath: history window, fill counter, signature table and search pipeline.
// Depends on bhsm_pkg.
module bhsm_dp
    import bhsm_pkg::*;
#(
    parameter int HISTORY_LEN    = DEF_HISTORY_LEN,
    parameter int MAX_SIGNATURES = DEF_MAX_SIGNATURES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bhsm_cmd_t          cmd,
    output bhsm_status_t       status,
    input  logic               branch_taken,
    input  logic [SIG_W-1:0]   signature_value,
    output logic               window_full,
    output logic               detected
);

    localparam int FW = $clog2(HISTORY_LEN + 1);
    localparam int CW = $clog2(MAX_SIGNATURES + 1);
    localparam int AW = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;

    logic [HISTORY_LEN-1:0] hist_reg;
    logic [HISTORY_LEN-1:0] hist_next;
    logic [FW-1:0]          fill_reg;
    logic [FW-1:0]          fill_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          idx_next;
    logic                   cmp_valid_reg;
    logic                   cmp_valid_next;
    logic                   issue;
    logic [SIG_W-1:0]       rd_data_reg;
    logic [SIG_W-1:0]       key;
    logic                   table_full;
    logic                   window_full_reg;
    logic                   detected_reg;
    logic [SIG_W-1:0]       sig_mem [MAX_SIGNATURES];

    assign table_full = (count_reg == CW'(MAX_SIGNATURES));
    assign key        = SIG_W'(hist_reg);
    assign hist_next  = (hist_reg << 1) | HISTORY_LEN'(branch_taken);
    assign fill_next  = (fill_reg == FW'(HISTORY_LEN)) ? fill_reg : fill_reg + FW'(1);

    assign issue          = cmd.srch_step && (idx_reg != count_reg);
    assign idx_next       = issue ? idx_reg + CW'(1) : idx_reg;
    assign cmp_valid_next = issue;

    assign status.full_after_shift = (fill_reg >= FW'(HISTORY_LEN - 1));
    assign status.table_empty      = (count_reg == '0);
    assign status.srch_hit         = cmp_valid_reg && (rd_data_reg == key);
    assign status.srch_miss        = cmp_valid_reg && (rd_data_reg != key)
                                     && (idx_reg == count_reg);

    assign window_full = window_full_reg;
    assign detected    = detected_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hist_shift)
            begin
                hist_reg <= hist_next;
                fill_reg <= fill_next;
            end
            if (cmd.load_wr && !table_full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.srch_clear)
            begin
                idx_reg       <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg       <= idx_next;
                cmp_valid_reg <= cmp_valid_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            window_full_reg <= cmd.res_full;
            detected_reg    <= cmd.res_hit;
        end
    end

    // Signature table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && !table_full)
        begin
            sig_mem[count_reg[AW-1:0]] <= signature_value;
        end
        if (issue)
        begin
            rd_data_reg <= sig_mem[idx_reg[AW-1:0]];
        end
    end

endmodule

@@ src/branch_history_signature_match.sv @@
// Branch history signature match: a window of the last HISTORY_LEN branch
// outcomes (newest in bit 0) is compared against a table of up to
// MAX_SIGNATURES 64-bit signatures appended by load transactions. Load and
// dropped branch transactions (from_main_image low) give no result. A
// branch transaction gives one result: while the window is not yet full,
// or the table is empty, the result is ready in the cycle after acceptance;
// otherwise the table's single read port is read one entry per cycle, and
// the search ends on a hit or once every stored signature is compared.
// One transaction is in flight at a time; the input stalls until the
// result is taken.
module branch_history_signature_match
    import bhsm_pkg::*;
#(
    parameter int HISTORY_LEN    = DEF_HISTORY_LEN,
    parameter int MAX_SIGNATURES = DEF_MAX_SIGNATURES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             mode,
    input  logic             branch_taken,
    input  logic             from_main_image,
    input  logic [SIG_W-1:0] signature_value,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             window_full,
    output logic             detected
);

    bhsm_cmd_t    cmd;
    bhsm_status_t status;

    bhsm_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .from_main_image (from_main_image),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cmd             (cmd),
        .status          (status)
    );

    bhsm_dp #(
        .HISTORY_LEN    (HISTORY_LEN),
        .MAX_SIGNATURES (MAX_SIGNATURES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .branch_taken    (branch_taken),
        .signature_value (signature_value),
        .window_full     (window_full),
        .detected        (detected)
    );

endmodule
